// ===== hw/rtl/iie_pkg.sv =====
// Package for the interpreter instruction execute unit.
// Opcode, ALU and register index codes, field widths and reset constants.
// No dependencies.
package iie_pkg;

  localparam int unsigned PC_W        = 12;
  localparam int unsigned LIMIT_W     = 13;
  localparam int unsigned REG_W       = 8;
  localparam int unsigned INSTR_W     = 16;
  localparam int unsigned KEY_W       = 16;
  localparam int unsigned CFG_AW      = 1;
  localparam int unsigned CFG_DW      = 13;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [PC_W-1:0]    RESET_PC        = 12'h200;
  localparam logic [LIMIT_W-1:0] RESET_PC_LIMIT  = 13'h0600;
  localparam logic [INSTR_W-1:0] W_CLS           = 16'h00E0;
  localparam logic [INSTR_W-1:0] W_RET           = 16'h00EE;
  localparam logic [REG_W-1:0]   KEY_SKP         = 8'h9E;
  localparam logic [REG_W-1:0]   KEY_SKNP        = 8'hA1;
  localparam logic [3:0]         FLAG_REG        = 4'hF;

  typedef enum logic [3:0] {
    OP_SYS     = 4'h0,
    OP_JP      = 4'h1,
    OP_CALL    = 4'h2,
    OP_SE_IMM  = 4'h3,
    OP_SNE_IMM = 4'h4,
    OP_SE_REG  = 4'h5,
    OP_LD_IMM  = 4'h6,
    OP_ADD_IMM = 4'h7,
    OP_ALU     = 4'h8,
    OP_SNE_REG = 4'h9,
    OP_LD_I    = 4'hA,
    OP_JP_V0   = 4'hB,
    OP_RND     = 4'hC,
    OP_DRAW    = 4'hD,
    OP_KEY     = 4'hE,
    OP_MISC    = 4'hF
  } op_t;

  typedef enum logic [3:0] {
    ALU_LD   = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_START_PC = 1'b0,
    CFG_PC_LIMIT = 1'b1
  } cfg_idx_t;

endpackage

// ===== hw/rtl/interpreter_instruction_execute_unit.sv =====
// Top level of the interpreter instruction execute unit.
// Input register, register file, return stack, execute logic and result register.
// Depends on iie_pkg.

// Executes one 16-bit instruction per transfer and returns one result per instruction.
// Throughput is one instruction per clock while out_stall is low. out_valid rises once
// the input transfer has passed the input register and then the result register; the
// byte register file is read as the input register loads. The input register and the
// result register decouple the two sides, so one more instruction is taken while a
// result waits. pc resets to 0x200; no start_pc register is kept, so a write to it
// never shows. pc_limit applies from the next instruction on. There is no clearing
// pass: byte registers read zero until first written.
module interpreter_instruction_execute_unit #(
  parameter int unsigned STACK_DEPTH = iie_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [iie_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [iie_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [iie_pkg::INSTR_W-1:0]       in_instr,
  input  logic [iie_pkg::KEY_W-1:0]         in_key_state,
  input  logic [iie_pkg::REG_W-1:0]         in_random_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [iie_pkg::PC_W-1:0]          out_pc_out,
  output logic [iie_pkg::PC_W-1:0]          out_index_out,
  output logic [iie_pkg::REG_W-1:0]         out_flag_out,
  output logic                              out_clear_screen,
  output logic                              out_unknown_op,
  output logic                              out_stack_fault,
  output logic                              out_halted
);

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW  = iie_pkg::PC_W;
  localparam int unsigned RW  = iie_pkg::REG_W;

  // configuration
  logic [iie_pkg::LIMIT_W-1:0] pc_limit_r;

  // input register
  logic                        in_vld_r;
  logic [iie_pkg::INSTR_W-1:0] instr_r;
  logic [iie_pkg::KEY_W-1:0]   keys_r;
  logic [RW-1:0]               rnd_r;
  logic                        in_acc;
  logic                        exe;
  logic [iie_pkg::INSTR_W-1:0] instr_nxt;

  // architectural state
  logic [PW-1:0]  pc_r;
  logic [PW-1:0]  idx_r;
  logic [SPW-1:0] sp_r;
  logic [RW-1:0]  vf_r;

  // register file (V0..VE; VF lives in vf_r)
  logic [RW-1:0] rf_mem [16];
  logic [15:0]   rf_ok_r;
  logic [RW-1:0] rdx_r;
  logic [RW-1:0] rdy_r;
  logic          rdx_ok_r;
  logic          rdy_ok_r;
  logic          wl_en_r;
  logic [3:0]    wl_a_r;
  logic [RW-1:0] wl_d_r;
  logic [3:0]    ax_nxt;
  logic [3:0]    ay_nxt;
  logic          rf_we;

  // return stack
  logic [PW-1:0] stk_mem [STACK_DEPTH];
  logic [PW-1:0] stk_rd_r;
  logic          push_last_r;
  logic [PW-1:0] push_d_r;
  logic [AW-1:0] stk_ra;
  logic [PW-1:0] tos;

  // result register
  logic          out_vld_r;
  logic [PW-1:0] out_pc_r;
  logic [PW-1:0] out_idx_r;
  logic [RW-1:0] out_flag_r;
  logic          out_cls_r;
  logic          out_unk_r;
  logic          out_fault_r;
  logic          out_halt_r;

  // execute
  iie_pkg::op_t  op;
  iie_pkg::alu_t alu;
  logic [3:0]    ax;
  logic [3:0]    ay;
  logic [RW-1:0] kk;
  logic [PW-1:0] nnn;
  logic [RW-1:0] vx;
  logic [RW-1:0] vy;
  logic [PW-1:0] pc_inc;
  logic [PW-1:0] pc_skip;
  logic          key_dn;
  logic [RW:0]   sum9;
  logic [PW-1:0] pc_exe;
  logic [PW-1:0] idx_exe;
  logic [SPW-1:0] sp_exe;
  logic [SPW-1:0] sp_nxt;
  logic          vx_we;
  logic [RW-1:0] vx_new;
  logic          flag_we;
  logic [RW-1:0] flag_val;
  logic [RW-1:0] vf_nxt;
  logic          cls;
  logic          unk;
  logic          fault;
  logic          push;

  // handshake
  assign exe       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !exe;
  assign in_acc    = in_valid && !in_stall;
  assign instr_nxt = in_acc ? in_instr : instr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_acc || (in_vld_r && !exe);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      instr_r <= in_instr;
      keys_r  <= in_key_state;
      rnd_r   <= in_random_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_limit_r <= iie_pkg::RESET_PC_LIMIT;
    end else if (cfg_we && (cfg_addr == iie_pkg::CFG_PC_LIMIT)) begin
      pc_limit_r <= cfg_wdata;
    end
  end

  // register file read addresses follow what the input register holds next cycle;
  // Bnnn reads V0 on the second port
  assign ax_nxt = instr_nxt[11:8];
  assign ay_nxt = (instr_nxt[15:12] == iie_pkg::OP_JP_V0) ? 4'h0 : instr_nxt[7:4];

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[ax] <= vx_new;
    end
    rdx_r    <= rf_mem[ax_nxt];
    rdy_r    <= rf_mem[ay_nxt];
    rdx_ok_r <= rf_ok_r[ax_nxt];
    rdy_ok_r <= rf_ok_r[ay_nxt];
    wl_a_r   <= ax;
    wl_d_r   <= vx_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_ok_r <= '0;
      wl_en_r <= 1'b0;
    end else begin
      wl_en_r <= rf_we;
      if (rf_we) begin
        rf_ok_r[ax] <= 1'b1;
      end
    end
  end

  // return stack: top entry for the next stack pointer read into a register, with the last push bypassed
  assign stk_ra = (sp_nxt == '0) ? '0 : AW'(sp_nxt - SPW'(1));

  always_ff @(posedge clk) begin
    if (exe && push) begin
      stk_mem[sp_r[AW-1:0]] <= pc_inc;
    end
    stk_rd_r <= stk_mem[stk_ra];
    push_d_r <= pc_inc;
  end

  assign tos = push_last_r ? push_d_r : stk_rd_r;

  // operand fetch
  assign op      = iie_pkg::op_t'(instr_r[15:12]);
  assign alu     = iie_pkg::alu_t'(instr_r[3:0]);
  assign ax      = instr_r[11:8];
  assign ay      = (op == iie_pkg::OP_JP_V0) ? 4'h0 : instr_r[7:4];
  assign kk      = instr_r[7:0];
  assign nnn     = instr_r[11:0];
  assign pc_inc  = pc_r + PW'(2);
  assign pc_skip = pc_r + PW'(4);

  always_comb begin
    if (ax == iie_pkg::FLAG_REG) begin
      vx = vf_r;
    end else if (wl_en_r && (wl_a_r == ax)) begin
      vx = wl_d_r;
    end else begin
      vx = rdx_ok_r ? rdx_r : '0;
    end
    if (ay == iie_pkg::FLAG_REG) begin
      vy = vf_r;
    end else if (wl_en_r && (wl_a_r == ay)) begin
      vy = wl_d_r;
    end else begin
      vy = rdy_ok_r ? rdy_r : '0;
    end
  end

  assign key_dn = keys_r[vx[3:0]];
  assign sum9   = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    pc_exe   = pc_inc;
    idx_exe  = idx_r;
    sp_exe   = sp_r;
    vx_we    = 1'b0;
    vx_new   = vx;
    flag_we  = 1'b0;
    flag_val = '0;
    cls      = 1'b0;
    unk      = 1'b0;
    fault    = 1'b0;
    push     = 1'b0;
    case (op)
      iie_pkg::OP_SYS: begin
        if (instr_r == iie_pkg::W_CLS) begin
          cls = 1'b1;
        end else if (instr_r == iie_pkg::W_RET) begin
          if (sp_r == '0) begin
            fault = 1'b1;
          end else begin
            sp_exe = sp_r - SPW'(1);
            pc_exe = tos;
          end
        end
      end
      iie_pkg::OP_JP: pc_exe = nnn;
      iie_pkg::OP_CALL: begin
        if (sp_r < SPW'(STACK_DEPTH)) begin
          push   = 1'b1;
          sp_exe = sp_r + SPW'(1);
          pc_exe = nnn;
        end else begin
          fault = 1'b1;
        end
      end
      iie_pkg::OP_SE_IMM:  if (vx == kk) pc_exe = pc_skip;
      iie_pkg::OP_SNE_IMM: if (vx != kk) pc_exe = pc_skip;
      iie_pkg::OP_SE_REG:  if (vx == vy) pc_exe = pc_skip;
      iie_pkg::OP_SNE_REG: if (vx != vy) pc_exe = pc_skip;
      iie_pkg::OP_LD_IMM: begin
        vx_we  = 1'b1;
        vx_new = kk;
      end
      iie_pkg::OP_ADD_IMM: begin
        vx_we  = 1'b1;
        vx_new = vx + kk;
      end
      iie_pkg::OP_ALU: begin
        case (alu)
          iie_pkg::ALU_LD: begin
            vx_we  = 1'b1;
            vx_new = vy;
          end
          iie_pkg::ALU_OR: begin
            vx_we  = 1'b1;
            vx_new = vx | vy;
          end
          iie_pkg::ALU_AND: begin
            vx_we  = 1'b1;
            vx_new = vx & vy;
          end
          iie_pkg::ALU_XOR: begin
            vx_we  = 1'b1;
            vx_new = vx ^ vy;
          end
          iie_pkg::ALU_ADD: begin
            vx_we    = 1'b1;
            vx_new   = sum9[RW-1:0];
            flag_we  = 1'b1;
            flag_val = RW'(sum9[RW]);
          end
          iie_pkg::ALU_SUB: begin
            vx_we    = 1'b1;
            vx_new   = vx - vy;
            flag_we  = 1'b1;
            flag_val = RW'(vx >= vy);
          end
          iie_pkg::ALU_SHR: begin
            vx_we    = 1'b1;
            vx_new   = {1'b0, vx[RW-1:1]};
            flag_we  = 1'b1;
            flag_val = RW'(vx[0]);
          end
          iie_pkg::ALU_SUBN: begin
            vx_we    = 1'b1;
            vx_new   = vy - vx;
            flag_we  = 1'b1;
            flag_val = RW'(vy >= vx);
          end
          iie_pkg::ALU_SHL: begin
            vx_we    = 1'b1;
            vx_new   = {vx[RW-2:0], 1'b0};
            flag_we  = 1'b1;
            flag_val = RW'(vx[RW-1]);
          end
          default: unk = 1'b1;
        endcase
      end
      iie_pkg::OP_LD_I:  idx_exe = nnn;
      iie_pkg::OP_JP_V0: pc_exe = nnn + PW'(vy);
      iie_pkg::OP_RND: begin
        vx_we  = 1'b1;
        vx_new = rnd_r & kk;
      end
      iie_pkg::OP_DRAW: ;
      iie_pkg::OP_KEY: begin
        if (kk == iie_pkg::KEY_SKP) begin
          if (key_dn) pc_exe = pc_skip;
        end else if (kk == iie_pkg::KEY_SKNP) begin
          if (!key_dn) pc_exe = pc_skip;
        end else begin
          unk = 1'b1;
        end
      end
      iie_pkg::OP_MISC: unk = 1'b1;
      default: unk = 1'b1;
    endcase
  end

  // flag wins over a result written to VF
  always_comb begin
    if (flag_we) begin
      vf_nxt = flag_val;
    end else if (vx_we && (ax == iie_pkg::FLAG_REG)) begin
      vf_nxt = vx_new;
    end else begin
      vf_nxt = vf_r;
    end
  end

  assign rf_we  = exe && vx_we && (ax != iie_pkg::FLAG_REG);
  assign sp_nxt = exe ? sp_exe : sp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= iie_pkg::RESET_PC;
      idx_r       <= '0;
      sp_r        <= '0;
      vf_r        <= '0;
      push_last_r <= 1'b0;
    end else begin
      push_last_r <= exe && push;
      if (exe) begin
        pc_r  <= pc_exe;
        idx_r <= idx_exe;
        sp_r  <= sp_exe;
        vf_r  <= vf_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= exe || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (exe) begin
      out_pc_r    <= pc_exe;
      out_idx_r   <= idx_exe;
      out_flag_r  <= vf_nxt;
      out_cls_r   <= cls;
      out_unk_r   <= unk;
      out_fault_r <= fault;
      out_halt_r  <= ({1'b0, pc_exe} >= pc_limit_r);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pc_out       = out_pc_r;
  assign out_index_out    = out_idx_r;
  assign out_flag_out     = out_flag_r;
  assign out_clear_screen = out_cls_r;
  assign out_unknown_op   = out_unk_r;
  assign out_stack_fault  = out_fault_r;
  assign out_halted       = out_halt_r;

  // checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_exe_result: assert property (@(posedge clk) disable iff (!rst_n)
    exe |=> out_valid)
    else $error("executed instruction produced no result");

  a_sp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r != $past(sp_r)) |-> ($past(exe) &&
      ((sp_r == $past(sp_r) + SPW'(1)) || (sp_r == $past(sp_r) - SPW'(1)))))
    else $error("stack pointer moved without a single push or pop");

endmodule

// ===== dv/interpreter_instruction_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for interpreter_instruction_execute_unit: directed, stack, limit and random tests.
// A predictor of the execute unit checks every result transfer field by field.
// Depends on iie_pkg and the unit's RTL.
module interpreter_instruction_execute_unit_tb;

  localparam int unsigned STACK_DEPTH = iie_pkg::STACK_DEPTH_DEF;
  localparam int unsigned WATCHDOG    = 2000;
  localparam logic [3:0]  ALU_BAD     = 4'hF;
  localparam iie_pkg::alu_t ALU_CODES [9] = '{
    iie_pkg::ALU_LD, iie_pkg::ALU_OR, iie_pkg::ALU_AND, iie_pkg::ALU_XOR, iie_pkg::ALU_ADD,
    iie_pkg::ALU_SUB, iie_pkg::ALU_SHR, iie_pkg::ALU_SUBN, iie_pkg::ALU_SHL};

  typedef struct packed {
    logic [iie_pkg::PC_W-1:0]  pc;
    logic [iie_pkg::PC_W-1:0]  index;
    logic [iie_pkg::REG_W-1:0] flag;
    logic                      clear_screen;
    logic                      unknown_op;
    logic                      stack_fault;
    logic                      halted;
  } exec_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [iie_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [iie_pkg::CFG_DW-1:0]   cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [iie_pkg::INSTR_W-1:0]  in_instr = '0;
  logic [iie_pkg::KEY_W-1:0]    in_key_state = '0;
  logic [iie_pkg::REG_W-1:0]    in_random_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [iie_pkg::PC_W-1:0]     out_pc_out;
  logic [iie_pkg::PC_W-1:0]     out_index_out;
  logic [iie_pkg::REG_W-1:0]    out_flag_out;
  logic                         out_clear_screen;
  logic                         out_unknown_op;
  logic                         out_stack_fault;
  logic                         out_halted;

  // predictor state
  logic [iie_pkg::REG_W-1:0]   vreg [16];
  logic [iie_pkg::PC_W-1:0]    pc_q;
  logic [iie_pkg::PC_W-1:0]    index_q;
  int unsigned                 sp_q;
  logic [iie_pkg::PC_W-1:0]    ret_stack [STACK_DEPTH];
  logic [iie_pkg::LIMIT_W-1:0] pc_limit_q;

  exec_result_t pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  gap_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  stall_left = 0;
  int unsigned  quiet_cycles = 0;

  interpreter_instruction_execute_unit #(.STACK_DEPTH(STACK_DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_instr         (in_instr),
    .in_key_state     (in_key_state),
    .in_random_byte   (in_random_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pc_out       (out_pc_out),
    .out_index_out    (out_index_out),
    .out_flag_out     (out_flag_out),
    .out_clear_screen (out_clear_screen),
    .out_unknown_op   (out_unknown_op),
    .out_stack_fault  (out_stack_fault),
    .out_halted       (out_halted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic exec_result_t execute_instr(logic [iie_pkg::INSTR_W-1:0] w,
                                                 logic [iie_pkg::KEY_W-1:0] keys,
                                                 logic [iie_pkg::REG_W-1:0] rnd);
    exec_result_t r;
    logic [3:0]                x;
    logic [3:0]                y;
    logic [3:0]                key;
    logic [iie_pkg::REG_W-1:0] kk;
    logic [iie_pkg::REG_W-1:0] a;
    logic [iie_pkg::REG_W-1:0] b;
    logic [iie_pkg::REG_W:0]   sum;
    logic [iie_pkg::PC_W-1:0]  nnn;
    logic [iie_pkg::PC_W-1:0]  pc;
    x   = w[11:8];
    y   = w[7:4];
    kk  = w[7:0];
    nnn = w[11:0];
    pc  = pc_q + 12'd2;
    r   = '0;
    case (iie_pkg::op_t'(w[15:12]))
      iie_pkg::OP_SYS: begin
        if (w == iie_pkg::W_CLS) begin
          r.clear_screen = 1'b1;
        end else if (w == iie_pkg::W_RET) begin
          if (sp_q == 0) begin
            r.stack_fault = 1'b1;
          end else begin
            sp_q--;
            pc = ret_stack[sp_q];
          end
        end
      end
      iie_pkg::OP_JP: pc = nnn;
      iie_pkg::OP_CALL: begin
        if (sp_q >= STACK_DEPTH) begin
          r.stack_fault = 1'b1;
        end else begin
          ret_stack[sp_q] = pc;
          sp_q++;
          pc = nnn;
        end
      end
      iie_pkg::OP_SE_IMM:  if (vreg[x] == kk) pc = pc + 12'd2;
      iie_pkg::OP_SNE_IMM: if (vreg[x] != kk) pc = pc + 12'd2;
      iie_pkg::OP_SE_REG:  if (vreg[x] == vreg[y]) pc = pc + 12'd2;
      iie_pkg::OP_LD_IMM:  vreg[x] = kk;
      iie_pkg::OP_ADD_IMM: vreg[x] = vreg[x] + kk;
      iie_pkg::OP_ALU: begin
        a = vreg[x];
        b = vreg[y];
        case (iie_pkg::alu_t'(w[3:0]))
          iie_pkg::ALU_LD:  vreg[x] = b;
          iie_pkg::ALU_OR:  vreg[x] = a | b;
          iie_pkg::ALU_AND: vreg[x] = a & b;
          iie_pkg::ALU_XOR: vreg[x] = a ^ b;
          iie_pkg::ALU_ADD: begin
            sum = a + b;
            vreg[x] = sum[7:0];
            vreg[iie_pkg::FLAG_REG] = {7'd0, sum[8]};
          end
          iie_pkg::ALU_SUB: begin
            vreg[x] = a - b;
            vreg[iie_pkg::FLAG_REG] = {7'd0, a >= b};
          end
          iie_pkg::ALU_SHR: begin
            vreg[x] = a >> 1;
            vreg[iie_pkg::FLAG_REG] = {7'd0, a[0]};
          end
          iie_pkg::ALU_SUBN: begin
            vreg[x] = b - a;
            vreg[iie_pkg::FLAG_REG] = {7'd0, b >= a};
          end
          iie_pkg::ALU_SHL: begin
            vreg[x] = a << 1;
            vreg[iie_pkg::FLAG_REG] = {7'd0, a[7]};
          end
          default: r.unknown_op = 1'b1;
        endcase
      end
      iie_pkg::OP_SNE_REG: if (vreg[x] != vreg[y]) pc = pc + 12'd2;
      iie_pkg::OP_LD_I:    index_q = nnn;
      iie_pkg::OP_JP_V0:   pc = nnn + iie_pkg::PC_W'(vreg[0]);
      iie_pkg::OP_RND:     vreg[x] = rnd & kk;
      iie_pkg::OP_DRAW:    ;
      iie_pkg::OP_KEY: begin
        key = vreg[x][3:0];
        if (kk == iie_pkg::KEY_SKP) begin
          if (keys[key]) pc = pc + 12'd2;
        end else if (kk == iie_pkg::KEY_SKNP) begin
          if (!keys[key]) pc = pc + 12'd2;
        end else begin
          r.unknown_op = 1'b1;
        end
      end
      default: r.unknown_op = 1'b1;
    endcase
    pc_q     = pc;
    r.pc     = pc;
    r.index  = index_q;
    r.flag   = vreg[iie_pkg::FLAG_REG];
    r.halted = {1'b0, pc} >= pc_limit_q;
    return r;
  endfunction

  // Mostly well-formed words; skips get operands that match about half the time.
  function automatic logic [iie_pkg::INSTR_W-1:0] pick_instr();
    logic [3:0]                op;
    logic [3:0]                x;
    logic [iie_pkg::REG_W-1:0] kk;
    op = 4'($urandom_range(0, 15));
    x  = 4'($urandom);
    kk = 8'($urandom);
    case (iie_pkg::op_t'(op))
      iie_pkg::OP_SYS: begin
        case ($urandom_range(0, 4))
          0, 1: return iie_pkg::W_CLS;
          2, 3: return iie_pkg::W_RET;
          default: ;
        endcase
      end
      iie_pkg::OP_SE_IMM, iie_pkg::OP_SNE_IMM: if ($urandom_range(0, 1)) kk = vreg[x];
      iie_pkg::OP_SE_REG, iie_pkg::OP_SNE_REG: begin
        if ($urandom_range(0, 1)) kk[7:4] = x;
        if ($urandom_range(0, 1)) kk[3:0] = 4'h0;
      end
      iie_pkg::OP_ALU: begin
        if ($urandom_range(0, 99) < 85) kk[3:0] = ALU_CODES[$urandom_range(0, 8)];
      end
      iie_pkg::OP_KEY: begin
        case ($urandom_range(0, 19))
          0, 1: ;
          2, 3, 4, 5, 6, 7, 8, 9, 10: kk = iie_pkg::KEY_SKP;
          default: kk = iie_pkg::KEY_SKNP;
        endcase
      end
      default: ;
    endcase
    return {op, x, kk};
  endfunction

  task automatic send_instr(input logic [iie_pkg::INSTR_W-1:0] w,
                            input logic [iie_pkg::KEY_W-1:0] keys,
                            input logic [iie_pkg::REG_W-1:0] rnd);
    exec_result_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_instr       <= w;
    in_key_state   <= keys;
    in_random_byte <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = execute_instr(w, keys, rnd);
    pending_results.push_back(r);
  endtask

  task automatic send_random(input int unsigned count);
    logic [iie_pkg::KEY_W-1:0] keys;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: keys = '0;
        1: keys = '1;
        default: keys = 16'($urandom);
      endcase
      send_instr(pick_instr(), keys, 8'($urandom));
    end
  endtask

  // Lowers valid and waits for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input iie_pkg::cfg_idx_t idx,
                           input logic [iie_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == iie_pkg::CFG_PC_LIMIT) pc_limit_q = val;
    @(posedge clk);
  endtask

  task automatic test_directed();
    gap_pct   = 20;
    stall_pct = 20;
    send_instr(iie_pkg::W_CLS, '0, '0);
    send_instr(iie_pkg::W_RET, '0, '0);
    send_instr({iie_pkg::OP_SYS, 12'h123}, '1, '1);
    send_instr({iie_pkg::OP_LD_IMM, 4'h1, 8'hFF}, '0, '0);
    send_instr({iie_pkg::OP_LD_IMM, 4'h2, 8'h01}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h1, 4'h2, iie_pkg::ALU_ADD}, '0, '0);
    send_instr({iie_pkg::OP_LD_IMM, 4'h1, 8'h80}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h1, 4'h2, iie_pkg::ALU_SUB}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h2, 4'h1, iie_pkg::ALU_SUB}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h1, 4'h2, iie_pkg::ALU_SUBN}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'hF, 4'h2, iie_pkg::ALU_SHR}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h1, 4'h2, iie_pkg::ALU_SHL}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h1, 4'h2, ALU_BAD}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h3, 4'h1, iie_pkg::ALU_OR}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h3, 4'h2, iie_pkg::ALU_AND}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h3, 4'h1, iie_pkg::ALU_XOR}, '0, '0);
    send_instr({iie_pkg::OP_ALU, 4'h4, 4'h1, iie_pkg::ALU_LD}, '0, '0);
    send_instr({iie_pkg::OP_SE_REG, 4'h1, 4'h4, 4'h7}, '0, '0);
    send_instr({iie_pkg::OP_SNE_REG, 4'h1, 4'h2, 4'h3}, '0, '0);
    send_instr({iie_pkg::OP_LD_I, 12'hFFF}, '0, '0);
    send_instr({iie_pkg::OP_LD_IMM, 4'h0, 8'h10}, '0, '0);
    send_instr({iie_pkg::OP_JP_V0, 12'hFFF}, '0, '0);
    send_instr({iie_pkg::OP_RND, 4'h3, 8'hFF}, '0, 8'hA5);
    send_instr({iie_pkg::OP_DRAW, 12'h123}, '0, '0);
    // key number above fifteen uses its low nibble
    send_instr({iie_pkg::OP_LD_IMM, 4'h4, 8'h13}, '0, '0);
    send_instr({iie_pkg::OP_KEY, 4'h4, iie_pkg::KEY_SKP}, 16'h0008, '0);
    send_instr({iie_pkg::OP_KEY, 4'h4, iie_pkg::KEY_SKNP}, 16'h0008, '0);
    send_instr({iie_pkg::OP_KEY, 4'h4, 8'h55}, '1, '0);
    send_instr({iie_pkg::OP_MISC, 12'h065}, '0, '0);
    send_instr({iie_pkg::OP_JP, 12'hFFC}, '0, '0);
    send_instr({iie_pkg::OP_SE_IMM, 4'h1, vreg[1]}, '0, '0);
    send_instr({iie_pkg::OP_CALL, 12'hABC}, '0, '0);
    send_instr(iie_pkg::W_RET, '0, '0);
  endtask

  task automatic test_stack_depth();
    while (sp_q < STACK_DEPTH) send_instr({iie_pkg::OP_CALL, 12'($urandom)}, '0, '0);
    send_instr({iie_pkg::OP_CALL, 12'($urandom)}, '0, '0);
    while (sp_q > 0) send_instr(iie_pkg::W_RET, '0, '0);
    send_instr(iie_pkg::W_RET, '0, '0);
  endtask

  task automatic test_limits();
    drain();
    write_cfg(iie_pkg::CFG_PC_LIMIT, '0);
    send_random(30);
    drain();
    write_cfg(iie_pkg::CFG_PC_LIMIT, 13'd4096);
    write_cfg(iie_pkg::CFG_START_PC, 13'hFFF);
    send_random(30);
    drain();
    write_cfg(iie_pkg::CFG_START_PC, '0);
    write_cfg(iie_pkg::CFG_PC_LIMIT, iie_pkg::RESET_PC_LIMIT);
    send_random(30);
  endtask

  task automatic test_random();
    int unsigned lim;
    for (int phase = 0; phase < 10; phase++) begin
      drain();
      case ($urandom_range(0, 3))
        0: lim = 0;
        1: lim = 4096;
        2: lim = (pc_q + $urandom_range(0, 8) > 4096) ? 4096 : pc_q + $urandom_range(0, 8);
        default: lim = $urandom_range(0, 4096);
      endcase
      write_cfg(iie_pkg::CFG_PC_LIMIT, iie_pkg::CFG_DW'(lim));
      if ($urandom_range(0, 1)) begin
        write_cfg(iie_pkg::CFG_START_PC, iie_pkg::CFG_DW'($urandom_range(0, 4095)));
      end
      gap_pct   = (phase == 9) ? 0 : $urandom_range(0, 3) * 10;
      stall_pct = (phase == 9) ? 0 : $urandom_range(0, 3) * 10;
      send_random(85);
    end
  endtask

  // receiver stalls: bursts of random length, occasional quiet stretches
  always @(posedge clk) begin
    if (!rst_n || stall_pct == 0) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet_cycles > 0) begin
      out_stall    <= 1'b0;
      quiet_cycles <= quiet_cycles - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 49) == 0) quiet_cycles <= $urandom_range(20, 80);
    end
  end

  task automatic cmp_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    exec_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        cmp_field("pc_out", exp_r.pc, out_pc_out);
        cmp_field("index_out", exp_r.index, out_index_out);
        cmp_field("flag_out", exp_r.flag, out_flag_out);
        cmp_field("clear_screen", exp_r.clear_screen, out_clear_screen);
        cmp_field("unknown_op", exp_r.unknown_op, out_unknown_op);
        cmp_field("stack_fault", exp_r.stack_fault, out_stack_fault);
        cmp_field("halted", exp_r.halted, out_halted);
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (vreg[i]) vreg[i] = '0;
    foreach (ret_stack[i]) ret_stack[i] = '0;
    pc_q       = iie_pkg::RESET_PC;
    index_q    = '0;
    sp_q       = 0;
    pc_limit_q = iie_pkg::RESET_PC_LIMIT;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_stack_depth();
    test_limits();
    test_random();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
